@@ rtl/j1939_periodic_tx_and_rx_matcher_core_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the message scheduler and matcher
// wraps concurrent checks so they drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef J1939_PERIODIC_TX_AND_RX_MATCHER_CORE_MACROS_SVH
`define J1939_PERIODIC_TX_AND_RX_MATCHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define JPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define JPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/jpt_pkg.sv @@
// ----------------------------------------------------------------------------
// jpt_pkg
// types and constants shared by the scheduler, its divider and the testbench
// ----------------------------------------------------------------------------
package jpt_pkg;

  // function codes of an input item
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_RX   = 2'd2;

  // entry kinds
  localparam logic [1:0] KIND_UNUSED = 2'd0;
  localparam logic [1:0] KIND_TX     = 2'd1;
  localparam logic [1:0] KIND_EXACT  = 2'd2;
  localparam logic [1:0] KIND_PDU    = 2'd3;

  // result kinds
  localparam logic OUT_TX = 1'b0;
  localparam logic OUT_RX = 1'b1;

  localparam logic [3:0]  MAX_LEN       = 4'd8;
  localparam logic [63:0] DATA_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] pgn;
    logic [1:0]  kind;
    logic [2:0]  prio;
    logic [3:0]  length;
    logic [15:0] interval;
  } entry_t;

  typedef struct packed {
    logic        out_kind;
    logic [3:0]  match_index;
    logic [28:0] identifier;
    logic [2:0]  prio;
    logic [15:0] pgn;
    logic [3:0]  length;
    logic [7:0]  source;
    logic [63:0] data;
    logic        last;
  } result_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_rsp_t;

  function automatic logic [3:0] sat_len(input logic [3:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

endpackage

@@ rtl/jpt_if.sv @@
// ----------------------------------------------------------------------------
// jpt channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface jpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  entry_index;
  logic [15:0] entry_pgn;
  logic [1:0]  entry_kind;
  logic [2:0]  entry_priority;
  logic [3:0]  entry_length;
  logic [15:0] entry_interval;
  logic [28:0] frame_id;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;

  modport source (output valid, func, entry_index, entry_pgn, entry_kind, entry_priority,
                  entry_length, entry_interval, frame_id, frame_length, frame_data,
                  input ready);
  modport sink (input valid, func, entry_index, entry_pgn, entry_kind, entry_priority,
                entry_length, entry_interval, frame_id, frame_length, frame_data,
                output ready);
endinterface

interface jpt_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [3:0]  match_index;
  logic [28:0] out_identifier;
  logic [2:0]  out_priority;
  logic [15:0] out_pgn;
  logic [3:0]  out_length;
  logic [7:0]  out_source;
  logic [63:0] out_data;
  logic        last;

  modport source (output valid, out_kind, match_index, out_identifier, out_priority, out_pgn,
                  out_length, out_source, out_data, last, input ready);
  modport sink (input valid, out_kind, match_index, out_identifier, out_priority, out_pgn,
                out_length, out_source, out_data, last, output ready);
endinterface

@@ rtl/jpt_mod_unit.sv @@
// ----------------------------------------------------------------------------
// jpt_mod_unit
// bit-serial restoring remainder, 32-bit dividend by 16-bit divisor
// ----------------------------------------------------------------------------
module jpt_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  jpt_pkg::div_req_t req,
  output jpt_pkg::div_rsp_t rsp
);
  import jpt_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] dvd_r;
  logic [15:0] dvs_r;
  logic [15:0] rem_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic [15:0] rem_nxt;

  // one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, dvd_r[31]};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[15:0] : trial[15:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == 16'd0);

endmodule

@@ rtl/j1939_periodic_tx_and_rx_matcher_core.sv @@
// ----------------------------------------------------------------------------
// j1939_periodic_tx_and_rx_matcher_core
// message table scheduler: periodic transmit requests and receive matching
// ----------------------------------------------------------------------------
// load item: written to the table as it is accepted. received frame: each table slot
// walked is read, then checked, and the first hit is handed over from the pending
// register. tick: each slot is read and checked, a periodic slot then waits on the serial
// remainder and passes a hit state when it fires; the table memory port and the divider set the walk time.
// reset clears the tick counter, own address and all slot valid bits at once.
module j1939_periodic_tx_and_rx_matcher_core #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  jpt_in_if.sink      in_ch,
  jpt_out_if.source   out_ch
);
  import jpt_pkg::*;
  `include "j1939_periodic_tx_and_rx_matcher_core_macros.svh"

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {IDLE, READ, CHECK, DIVIDE, HIT, FLUSH} state_t;

  state_t          state_r;
  logic [7:0]      own_r;
  logic [31:0]     tick_r;
  logic [IW-1:0]   idx_r;
  logic [1:0]      func_r;
  logic [28:0]     fid_r;
  logic [3:0]      flen_r;
  logic [63:0]     fdata_r;
  entry_t          ent_r;
  entry_t          mem [ENTRIES];
  entry_t          rd_data_r;
  logic            rd_vld_r;
  logic [ENTRIES-1:0] vld_r;
  result_t         pend_r;
  logic            pend_v_r;
  result_t         out_r;
  logic            out_v_r;
  entry_t          ent_cur;
  logic            in_xfer;
  logic            load_ok;
  logic            out_free;
  logic            rx_hit;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  result_t         tx_res;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign load_ok  = in_xfer && (in_ch.func == FUNC_LOAD) && (32'(in_ch.entry_index) < ENTRIES);
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == IDLE);

  // table memory, one read port registered
  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[IW'(in_ch.entry_index)] <= '{pgn: in_ch.entry_pgn, kind: in_ch.entry_kind,
                                      prio: in_ch.entry_priority,
                                      length: in_ch.entry_length,
                                      interval: in_ch.entry_interval};
    end
    rd_data_r <= mem[idx_r];
  end

  // slot valid bits, unwritten slots read as unused
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (load_ok) vld_r[IW'(in_ch.entry_index)] <= 1'b1;
      rd_vld_r <= vld_r[idx_r];
    end
  end

  assign ent_cur = rd_vld_r ? rd_data_r : '0;

  // receive match on current slot
  always_comb begin
    rx_hit = 1'b0;
    unique case (ent_cur.kind)
      KIND_EXACT: rx_hit = (ent_cur.pgn == fid_r[23:8]);
      KIND_PDU:   rx_hit = (ent_cur.pgn[15:12] == fid_r[23:20]);
      default:    rx_hit = 1'b0;
    endcase
  end

  // transmit request from latched slot, last when the walk ends here
  always_comb begin
    tx_res.out_kind    = OUT_TX;
    tx_res.match_index = 4'(idx_r);
    tx_res.identifier  = {ent_r.prio, 2'b00, ent_r.pgn, own_r};
    tx_res.prio        = ent_r.prio;
    tx_res.pgn         = ent_r.pgn;
    tx_res.length      = sat_len(ent_r.length);
    tx_res.source      = own_r;
    tx_res.data        = DATA_ALL_ONES;
    tx_res.last        = (idx_r == LAST_IDX);
  end

  // divider request
  always_comb begin
    div_req.start    = (state_r == CHECK) && (func_r == FUNC_TICK) &&
                       (ent_cur.kind == KIND_TX) && (ent_cur.interval != 16'd0);
    div_req.dividend = tick_r;
    div_req.divisor  = ent_cur.interval;
  end

  jpt_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer with pending and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= IDLE;
      own_r    <= '0;
      tick_r   <= '0;
      idx_r    <= '0;
      func_r   <= FUNC_LOAD;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) own_r <= cfg_data;
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (in_xfer && (in_ch.func == FUNC_TICK || in_ch.func == FUNC_RX)) begin
            func_r  <= in_ch.func;
            fid_r   <= in_ch.frame_id;
            flen_r  <= in_ch.frame_length;
            fdata_r <= in_ch.frame_data;
            idx_r   <= '0;
            state_r <= READ;
            if (in_ch.func == FUNC_TICK) tick_r <= tick_r + 32'd1;
          end
        end
        READ: state_r <= CHECK;
        CHECK: begin
          ent_r <= ent_cur;
          if (div_req.start) begin
            state_r <= DIVIDE;
          end else if (func_r == FUNC_RX && rx_hit) begin
            pend_r   <= '{out_kind: OUT_RX, match_index: 4'(idx_r), identifier: fid_r,
                          prio: fid_r[28:26], pgn: fid_r[23:8],
                          length: sat_len(flen_r), source: fid_r[7:0],
                          data: fdata_r, last: 1'b1};
            pend_v_r <= 1'b1;
            state_r  <= FLUSH;
          end else if (idx_r == LAST_IDX) begin
            pend_r.last <= 1'b1;
            state_r     <= pend_v_r ? FLUSH : IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= READ;
          end
        end
        DIVIDE: begin
          if (div_rsp.done) begin
            if (div_rsp.rem_zero) begin
              state_r <= HIT;
            end else if (idx_r == LAST_IDX) begin
              pend_r.last <= 1'b1;
              state_r     <= pend_v_r ? FLUSH : IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= READ;
            end
          end
        end
        HIT: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_r   <= pend_r;
              out_v_r <= 1'b1;
            end
            pend_r   <= tx_res;
            pend_v_r <= 1'b1;
            if (idx_r == LAST_IDX) begin
              state_r <= FLUSH;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= READ;
            end
          end
        end
        FLUSH: begin
          if (out_free) begin
            out_r    <= pend_r;
            out_v_r  <= 1'b1;
            pend_v_r <= 1'b0;
            state_r  <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_kind       = out_r.out_kind;
  assign out_ch.match_index    = out_r.match_index;
  assign out_ch.out_identifier = out_r.identifier;
  assign out_ch.out_priority   = out_r.prio;
  assign out_ch.out_pgn        = out_r.pgn;
  assign out_ch.out_length     = out_r.length;
  assign out_ch.out_source     = out_r.source;
  assign out_ch.out_data       = out_r.data;
  assign out_ch.last           = out_r.last;

  `JPT_ASSERT_IMP(a_div_in_divide, clk, rst_n, div_rsp.busy, state_r == DIVIDE, "divider busy outside divide")
  `JPT_ASSERT_IMP(a_flush_pending, clk, rst_n, state_r == FLUSH, pend_v_r, "flush without pending result")
  `JPT_ASSERT_IMP(a_idle_empty, clk, rst_n, state_r == IDLE, !pend_v_r, "pending result left in idle")
  `JPT_ASSERT_NXT(a_tick_step, clk, rst_n, in_xfer && in_ch.func == FUNC_TICK, tick_r == $past(tick_r) + 32'd1, "tick counter not advanced")

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// message scheduler and matcher testbench
// drives load, tick and received-frame items with random gaps on both
// channels, predicts transmit requests and deliveries, checks every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import jpt_pkg::*;

  class msg_scoreboard;
    entry_t      slots [16];
    logic [31:0] ticks;
    logic [7:0]  src_addr;
    result_t     pending [$];
    int          errors;

    function void clear();
      foreach (slots[i]) slots[i] = '0;
      ticks = '0;
      src_addr = '0;
      pending.delete();
      errors = 0;
    endfunction

    // work out the results of one accepted input item
    function void note_item(logic [1:0] fn, logic [3:0] idx, entry_t e,
                            logic [28:0] fid, logic [3:0] flen, logic [63:0] fdata);
      result_t r;
      int first;
      first = pending.size();
      if (fn == FUNC_LOAD) begin
        slots[idx] = e;
      end else if (fn == FUNC_TICK) begin
        ticks = ticks + 32'd1;
        for (int i = 0; i < 16; i++) begin
          if (slots[i].kind == KIND_TX && slots[i].interval != 0 &&
              (ticks % slots[i].interval) == 0) begin
            r.out_kind = OUT_TX;
            r.match_index = 4'(i);
            r.identifier = {slots[i].prio, 2'b00, slots[i].pgn, src_addr};
            r.prio = slots[i].prio;
            r.pgn = slots[i].pgn;
            r.length = (slots[i].length > 8) ? 4'd8 : slots[i].length;
            r.source = src_addr;
            r.data = '1;
            r.last = 1'b0;
            pending.push_back(r);
          end
        end
      end else if (fn == FUNC_RX) begin
        for (int i = 0; i < 16; i++) begin
          if ((slots[i].kind == KIND_EXACT && slots[i].pgn == fid[23:8]) ||
              (slots[i].kind == KIND_PDU && slots[i].pgn[15:12] == fid[23:20])) begin
            r.out_kind = OUT_RX;
            r.match_index = 4'(i);
            r.identifier = fid;
            r.prio = fid[28:26];
            r.pgn = fid[23:8];
            r.length = (flen > 8) ? 4'd8 : flen;
            r.source = fid[7:0];
            r.data = fdata;
            r.last = 1'b0;
            pending.push_back(r);
            break;
          end
        end
      end
      if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      w = pending.pop_front();
      if (got.out_kind !== w.out_kind) report("out_kind");
      if (got.match_index !== w.match_index) report("match_index");
      if (got.identifier !== w.identifier) report($sformatf("identifier %h/%h",
                                                            got.identifier, w.identifier));
      if (got.prio !== w.prio) report("priority");
      if (got.pgn !== w.pgn) report("pgn");
      if (got.length !== w.length) report("length");
      if (got.source !== w.source) report("source");
      if (got.data !== w.data) report("data");
      if (got.last !== w.last) report("last");
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  int cycles = 0;
  msg_scoreboard sb;

  jpt_in_if in_ch ();
  jpt_out_if out_ch ();

  j1939_periodic_tx_and_rx_matcher_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.entry_index = '0;
    in_ch.entry_pgn = '0;
    in_ch.entry_kind = '0;
    in_ch.entry_priority = '0;
    in_ch.entry_length = '0;
    in_ch.entry_interval = '0;
    in_ch.frame_id = '0;
    in_ch.frame_length = '0;
    in_ch.frame_data = '0;
    out_ch.ready = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random ready, check every transfer
  initial begin
    result_t got;
    int g;
    @(posedge clk iff rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.out_kind = out_ch.out_kind;
        got.match_index = out_ch.match_index;
        got.identifier = out_ch.out_identifier;
        got.prio = out_ch.out_priority;
        got.pgn = out_ch.out_pgn;
        got.length = out_ch.out_length;
        got.source = out_ch.out_source;
        got.data = out_ch.out_data;
        got.last = out_ch.last;
        sb.check_result(got);
      end
    end
  end

  task automatic send_item(logic [1:0] fn, logic [3:0] idx, entry_t e,
                           logic [28:0] fid, logic [3:0] flen, logic [63:0] fdata);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.entry_index <= idx;
    in_ch.entry_pgn <= e.pgn;
    in_ch.entry_kind <= e.kind;
    in_ch.entry_priority <= e.prio;
    in_ch.entry_length <= e.length;
    in_ch.entry_interval <= e.interval;
    in_ch.frame_id <= fid;
    in_ch.frame_length <= flen;
    in_ch.frame_data <= fdata;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(fn, idx, e, fid, flen, fdata);
  endtask

  task automatic load_slot(logic [3:0] idx, logic [15:0] pgn, logic [1:0] k,
                           logic [2:0] pri, logic [3:0] len, logic [15:0] iv);
    entry_t e;
    e.pgn = pgn; e.kind = k; e.prio = pri; e.length = len; e.interval = iv;
    send_item(FUNC_LOAD, idx, e, 29'($urandom), 4'($urandom), {$urandom, $urandom});
  endtask

  task automatic tick();
    send_item(FUNC_TICK, 4'($urandom), entry_t'(43'({$urandom, $urandom})),
              29'($urandom), 4'($urandom), {$urandom, $urandom});
  endtask

  task automatic rx_frame(logic [28:0] fid, logic [3:0] flen, logic [63:0] fdata);
    send_item(FUNC_RX, 4'($urandom), entry_t'(43'({$urandom, $urandom})), fid, flen, fdata);
  endtask

  // idle the input side, wait for every expected result, then allow the longest walk to finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic set_address(logic [7:0] a);
    cfg_we <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.src_addr = a;
  endtask

  function automatic logic [15:0] known_pgn(int s);
    return 16'(16'h1000 * s + 16'h0123);
  endfunction

  initial begin
    logic [28:0] fid;
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, all kinds, no match, long lengths, unknown func
    set_address(8'hFF);
    load_slot(0, 16'hFFFF, KIND_TX, 3'd7, 4'd15, 16'd1);
    load_slot(15, 16'h0000, KIND_TX, 3'd0, 4'd0, 16'd2);
    load_slot(3, 16'hFEEF, KIND_EXACT, 3'd5, 4'd3, 16'hFFFF);
    load_slot(4, 16'hA000, KIND_PDU, 3'd1, 4'd8, 16'd0);
    load_slot(5, 16'h1234, KIND_TX, 3'd2, 4'd4, 16'd0);
    load_slot(6, 16'h5555, KIND_UNUSED, 3'd3, 4'd9, 16'd1);
    tick(); tick(); tick();
    rx_frame({3'd7, 2'b11, 16'hFEEF, 8'hFF}, 4'd15, '1);
    rx_frame({3'd0, 2'b00, 16'hA9FF, 8'h00}, 4'd0, '0);
    rx_frame({3'd4, 2'b10, 16'h2222, 8'h5A}, 4'd8, 64'h0123456789ABCDEF);
    send_item(2'd3, 4'd1, '1, '1, 4'd1, '1);
    load_slot(7, 16'hFEEF, KIND_EXACT, 3'd0, 4'd0, 16'd0);
    rx_frame({3'd0, 2'b00, 16'hFEEF, 8'h12}, 4'd7, {$urandom, $urandom});
    drain();
    set_address(8'h00);
    for (int i = 0; i < 16; i++) begin
      load_slot(4'(i), 16'($urandom), KIND_TX, 3'($urandom), 4'($urandom), 16'd1);
    end
    tick();
    drain();
    set_address(8'h3C);

    // random: mostly matching frames and short intervals
    for (int n = 0; n < 330; n++) begin
      int p;
      p = $urandom_range(0, 99);
      if (n == 160) begin
        drain();
        set_address(8'($urandom));
      end
      if (p < 25) begin
        load_slot(4'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : known_pgn($urandom_range(0, 15)),
                  2'($urandom), 3'($urandom), 4'($urandom),
                  ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
      end else if (p < 60) begin
        tick();
      end else if (p < 97) begin
        fid = 29'($urandom);
        if ($urandom_range(0, 2) != 0) fid[23:8] = known_pgn($urandom_range(0, 15));
        rx_frame(fid, 4'($urandom), {$urandom, $urandom});
      end else begin
        send_item(2'd3, 4'($urandom), entry_t'(43'({$urandom, $urandom})),
                  29'($urandom), 4'($urandom), {$urandom, $urandom});
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
